FILE: hw/rtl/tpcr_pkg.sv
// Shared constants, codes and types of the touch point calibrate/rotate block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package tpcr_pkg;

  localparam int RAW_BITS   = 10;
  localparam int DIM_BITS   = 10;
  localparam int ROT_BITS   = 2;
  localparam int PRESS_BITS = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;

  localparam int NUM_W              = RAW_BITS + DIM_BITS;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = DIM_BITS / DIV_BITS_PER_STAGE;
  localparam int LANES              = 2;
  localparam int PIPE_STAGES        = 2 + DIV_STAGES;

  localparam logic signed [PRESS_BITS-1:0] PRESS_LOW  = 16'sd200;
  localparam logic signed [PRESS_BITS-1:0] PRESS_HIGH = 16'sd1000;

  localparam logic [RAW_BITS-1:0] CAL_MIN_RST = '0;
  localparam logic [RAW_BITS-1:0] CAL_MAX_RST = {RAW_BITS{1'b1}};
  localparam logic [DIM_BITS-1:0] WIDTH_RST   = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] HEIGHT_RST  = DIM_BITS'(480);

  typedef enum logic [ROT_BITS-1:0] {
    ROT_PORTRAIT       = 2'd0,
    ROT_LANDSCAPE      = 2'd1,
    ROT_PORTRAIT_FLIP  = 2'd2,
    ROT_LANDSCAPE_FLIP = 2'd3
  } rot_e;

  typedef enum logic [ADDR_W-3:0] {
    REG_CAL_MIN_X     = 3'd0,
    REG_CAL_MAX_X     = 3'd1,
    REG_CAL_MIN_Y     = 3'd2,
    REG_CAL_MAX_Y     = 3'd3,
    REG_ROTATION      = 3'd4,
    REG_NATIVE_WIDTH  = 3'd5,
    REG_NATIVE_HEIGHT = 3'd6
  } reg_e;

  typedef struct packed {
    logic [RAW_BITS-1:0] cal_min_x;
    logic [RAW_BITS-1:0] cal_max_x;
    logic [RAW_BITS-1:0] cal_min_y;
    logic [RAW_BITS-1:0] cal_max_y;
    rot_e                rotation;
    logic [DIM_BITS-1:0] native_width;
    logic [DIM_BITS-1:0] native_height;
  } cfg_t;

  // First stage of one axis: signed offsets from the span start
  typedef struct packed {
    logic signed [RAW_BITS:0] dv;
    logic signed [RAW_BITS:0] dn;
    logic [DIM_BITS-1:0]      top;
    logic                     dim_zero;
  } s1_lane_t;

  // Flags that ride along with an axis through the divider
  typedef struct packed {
    logic                touched;
    logic                force_zero;
    logic                force_top;
    logic [DIM_BITS-1:0] top;
  } lane_t;

endpackage

FILE: hw/rtl/tpcr_in_if.sv
// Request channel carrying one raw touch sample.
// Depends on tpcr_pkg for field widths.
`timescale 1ns / 1ps

interface tpcr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [tpcr_pkg::RAW_BITS-1:0]          raw_x;
  logic [tpcr_pkg::RAW_BITS-1:0]          raw_y;
  logic signed [tpcr_pkg::PRESS_BITS-1:0] pressure;

  modport source (output valid, output raw_x, output raw_y, output pressure, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input pressure, output ready);
endinterface

FILE: hw/rtl/tpcr_out_if.sv
// Request channel carrying one mapped screen coordinate.
// Depends on tpcr_pkg for field widths.
`timescale 1ns / 1ps

interface tpcr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          touched;
  logic [tpcr_pkg::DIM_BITS-1:0] screen_x;
  logic [tpcr_pkg::DIM_BITS-1:0] screen_y;

  modport source (output valid, output touched, output screen_x, output screen_y, input ready);
  modport sink   (input valid, input touched, input screen_x, input screen_y, output ready);
endinterface

FILE: hw/rtl/tpcr_cfg_regs.sv
// APB-style register file: calibration span, rotation and native panel size.
// Depends on tpcr_pkg.
`timescale 1ns / 1ps

module tpcr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpcr_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpcr_pkg::DATA_W-1:0]   pwdata,
  output logic [tpcr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output tpcr_pkg::cfg_t                cfg_o
);
  import tpcr_pkg::*;

  cfg_t cfg_q;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_min_x     <= CAL_MIN_RST;
      cfg_q.cal_max_x     <= CAL_MAX_RST;
      cfg_q.cal_min_y     <= CAL_MIN_RST;
      cfg_q.cal_max_y     <= CAL_MAX_RST;
      cfg_q.rotation      <= ROT_PORTRAIT;
      cfg_q.native_width  <= WIDTH_RST;
      cfg_q.native_height <= HEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CAL_MIN_X:     cfg_q.cal_min_x     <= pwdata[RAW_BITS-1:0];
        REG_CAL_MAX_X:     cfg_q.cal_max_x     <= pwdata[RAW_BITS-1:0];
        REG_CAL_MIN_Y:     cfg_q.cal_min_y     <= pwdata[RAW_BITS-1:0];
        REG_CAL_MAX_Y:     cfg_q.cal_max_y     <= pwdata[RAW_BITS-1:0];
        REG_ROTATION:      cfg_q.rotation      <= rot_e'(pwdata[ROT_BITS-1:0]);
        REG_NATIVE_WIDTH:  cfg_q.native_width  <= pwdata[DIM_BITS-1:0];
        REG_NATIVE_HEIGHT: cfg_q.native_height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CAL_MIN_X:     prdata = DATA_W'(cfg_q.cal_min_x);
      REG_CAL_MAX_X:     prdata = DATA_W'(cfg_q.cal_max_x);
      REG_CAL_MIN_Y:     prdata = DATA_W'(cfg_q.cal_min_y);
      REG_CAL_MAX_Y:     prdata = DATA_W'(cfg_q.cal_max_y);
      REG_ROTATION:      prdata = DATA_W'(cfg_q.rotation);
      REG_NATIVE_WIDTH:  prdata = DATA_W'(cfg_q.native_width);
      REG_NATIVE_HEIGHT: prdata = DATA_W'(cfg_q.native_height);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/tpcr_div_pipe.sv
// Pipelined restoring divider for one axis, two quotient bits per stage.
// Depends on tpcr_pkg. The quotient is known to fit DIM_BITS unless force_top is set.
`timescale 1ns / 1ps

module tpcr_div_pipe (
  input  logic                                clk_i,
  input  logic [tpcr_pkg::DIV_STAGES-1:0]     en_i,
  input  logic [tpcr_pkg::NUM_W-1:0]          num_i,
  input  logic [tpcr_pkg::RAW_BITS-1:0]       den_i,
  input  tpcr_pkg::lane_t                     side_i,
  output logic [tpcr_pkg::DIM_BITS-1:0]       quo_o,
  output tpcr_pkg::lane_t                     side_o
);
  import tpcr_pkg::*;

  typedef struct packed {
    logic [RAW_BITS-1:0] rem;
    logic [DIM_BITS-1:0] low;
    logic [DIM_BITS-1:0] quo;
    logic [RAW_BITS-1:0] den;
    lane_t               side;
  } dstage_t;

  dstage_t load;
  dstage_t st_d [DIV_STAGES];
  dstage_t st_q [DIV_STAGES];

  // upper dividend bits already sit below the divisor, so start there
  always_comb begin
    load.rem  = num_i[NUM_W-1:DIM_BITS];
    load.low  = num_i[DIM_BITS-1:0];
    load.quo  = '0;
    load.den  = den_i;
    load.side = side_i;
  end

  always_comb begin
    dstage_t              cur;
    logic [RAW_BITS:0]    t;
    logic                 ge;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = (k == 0) ? load : st_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        t       = {cur.rem, cur.low[DIM_BITS-1]};
        cur.low = {cur.low[DIM_BITS-2:0], 1'b0};
        ge      = t >= {1'b0, cur.den};
        cur.rem = ge ? RAW_BITS'(t - {1'b0, cur.den}) : t[RAW_BITS-1:0];
        cur.quo = {cur.quo[DIM_BITS-2:0], ge};
      end
      st_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign quo_o  = st_q[DIV_STAGES-1].quo;
  assign side_o = st_q[DIV_STAGES-1].side;

endmodule

FILE: hw/rtl/touch_point_calibrate_rotate.sv
// Maps raw resistive-touch samples to clamped screen coordinates. One sample is
// accepted every clock cycle while the result side takes results; a result passes
// through operand select, multiply, five divider stages of two quotient bits each
// and the output register: eight registers, the first loaded at the edge that
// accepts its request. The result is held there until the result side takes it.
// While the result side stalls, requests are still accepted until every stage is full.
// Depends on tpcr_pkg, tpcr_in_if, tpcr_out_if, tpcr_cfg_regs and tpcr_div_pipe.
`timescale 1ns / 1ps

module touch_point_calibrate_rotate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tpcr_in_if.sink                       in_i,
  tpcr_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpcr_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpcr_pkg::DATA_W-1:0]   pwdata,
  output logic [tpcr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tpcr_pkg::*;

  cfg_t                cfg;
  logic [RAW_BITS-1:0] sel_v   [LANES];
  logic [RAW_BITS-1:0] sel_a   [LANES];
  logic [RAW_BITS-1:0] sel_b   [LANES];
  logic [DIM_BITS-1:0] sel_dim [LANES];

  s1_lane_t            s1_d [LANES];
  s1_lane_t            s1_q [LANES];
  logic                touched_d;
  logic                s1_touched_q;

  logic [RAW_BITS:0]   dv_abs  [LANES];
  logic [RAW_BITS:0]   dn_abs  [LANES];
  lane_t               s2_d    [LANES];
  lane_t               s2_q    [LANES];
  logic [NUM_W-1:0]    num_d   [LANES];
  logic [NUM_W-1:0]    num_q   [LANES];
  logic [RAW_BITS-1:0] den_d   [LANES];
  logic [RAW_BITS-1:0] den_q   [LANES];

  logic [DIM_BITS-1:0] quo     [LANES];
  lane_t               side    [LANES];
  logic [DIM_BITS-1:0] res     [LANES];

  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES:0]   en;

  logic                out_valid_q;
  logic                out_touched_q;
  logic [DIM_BITS-1:0] out_x_q;
  logic [DIM_BITS-1:0] out_y_q;

  tpcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A stage loads when it is empty or the stage after it moves on
  always_comb begin
    en[PIPE_STAGES] = !out_valid_q || out_o.ready;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k - 1];
        end
      end
      if (en[PIPE_STAGES]) begin
        out_valid_q <= v_q[PIPE_STAGES-1];
      end
    end
  end

  // Stage 1: pick axis, span direction and dimension per rotation.
  // Lane 0 feeds screen_x, lane 1 feeds screen_y.
  always_comb begin
    sel_v[0] = in_i.raw_x;  sel_a[0] = cfg.cal_max_x;  sel_b[0] = cfg.cal_min_x;
    sel_dim[0] = cfg.native_width;
    sel_v[1] = in_i.raw_y;  sel_a[1] = cfg.cal_min_y;  sel_b[1] = cfg.cal_max_y;
    sel_dim[1] = cfg.native_height;
    case (cfg.rotation)
      ROT_PORTRAIT: begin
        sel_v[0] = in_i.raw_x;  sel_a[0] = cfg.cal_max_x;  sel_b[0] = cfg.cal_min_x;
        sel_dim[0] = cfg.native_width;
        sel_v[1] = in_i.raw_y;  sel_a[1] = cfg.cal_min_y;  sel_b[1] = cfg.cal_max_y;
        sel_dim[1] = cfg.native_height;
      end
      ROT_LANDSCAPE: begin
        sel_v[0] = in_i.raw_y;  sel_a[0] = cfg.cal_min_y;  sel_b[0] = cfg.cal_max_y;
        sel_dim[0] = cfg.native_height;
        sel_v[1] = in_i.raw_x;  sel_a[1] = cfg.cal_min_x;  sel_b[1] = cfg.cal_max_x;
        sel_dim[1] = cfg.native_width;
      end
      ROT_PORTRAIT_FLIP: begin
        sel_v[0] = in_i.raw_x;  sel_a[0] = cfg.cal_min_x;  sel_b[0] = cfg.cal_max_x;
        sel_dim[0] = cfg.native_width;
        sel_v[1] = in_i.raw_y;  sel_a[1] = cfg.cal_max_y;  sel_b[1] = cfg.cal_min_y;
        sel_dim[1] = cfg.native_height;
      end
      ROT_LANDSCAPE_FLIP: begin
        sel_v[0] = in_i.raw_y;  sel_a[0] = cfg.cal_max_y;  sel_b[0] = cfg.cal_min_y;
        sel_dim[0] = cfg.native_height;
        sel_v[1] = in_i.raw_x;  sel_a[1] = cfg.cal_max_x;  sel_b[1] = cfg.cal_min_x;
        sel_dim[1] = cfg.native_width;
      end
      default: ;
    endcase
    for (int l = 0; l < LANES; l++) begin
      s1_d[l].dv       = $signed({1'b0, sel_v[l]}) - $signed({1'b0, sel_a[l]});
      s1_d[l].dn       = $signed({1'b0, sel_b[l]}) - $signed({1'b0, sel_a[l]});
      s1_d[l].top      = sel_dim[l] - DIM_BITS'(1);
      s1_d[l].dim_zero = (sel_dim[l] == '0);
    end
    touched_d = (in_i.pressure > PRESS_LOW) && (in_i.pressure < PRESS_HIGH);
  end

  // Stage 2: magnitudes, early-out flags and the product.
  // Opposite signs clamp to zero; |v-a| >= |b-a| saturates at top.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dv_abs[l] = s1_q[l].dv[RAW_BITS] ? -s1_q[l].dv : s1_q[l].dv;
      dn_abs[l] = s1_q[l].dn[RAW_BITS] ? -s1_q[l].dn : s1_q[l].dn;
      s2_d[l].touched    = s1_touched_q;
      s2_d[l].force_zero = !s1_touched_q || s1_q[l].dim_zero || (s1_q[l].dn == '0) ||
                           (s1_q[l].dv == '0) || (s1_q[l].dv[RAW_BITS] ^ s1_q[l].dn[RAW_BITS]);
      s2_d[l].force_top  = dv_abs[l][RAW_BITS-1:0] >= dn_abs[l][RAW_BITS-1:0];
      s2_d[l].top        = s1_q[l].top;
      num_d[l] = NUM_W'(dv_abs[l][RAW_BITS-1:0]) * NUM_W'(s1_q[l].top);
      den_d[l] = dn_abs[l][RAW_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q         <= s1_d;
      s1_touched_q <= touched_d;
    end
    if (en[1]) begin
      s2_q  <= s2_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tpcr_div_pipe u_div (
      .clk_i  (clk_i),
      .en_i   (en[PIPE_STAGES-1:2]),
      .num_i  (num_q[l]),
      .den_i  (den_q[l]),
      .side_i (s2_q[l]),
      .quo_o  (quo[l]),
      .side_o (side[l])
    );
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      res[l] = side[l].force_zero ? '0 :
               side[l].force_top  ? side[l].top : quo[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[PIPE_STAGES]) begin
      out_touched_q <= side[0].touched;
      out_x_q       <= res[0];
      out_y_q       <= res[1];
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.touched  = out_touched_q;
  assign out_o.screen_x = out_x_q;
  assign out_o.screen_y = out_y_q;

endmodule
